### src/satpc_pkg.sv
// Shared constants of the polygon collision tester.
// No dependencies; used by sat_polygon_collision.
package satpc_pkg;

  // Port width of one vertex coordinate field
  localparam int unsigned FIELD_W = 16;

  // Shape tags carried by shape_sel
  localparam logic SHAPE_A = 1'b0;
  localparam logic SHAPE_B = 1'b1;

endpackage

### src/sat_polygon_collision.sv
// Separating axis collision test of two convex polygons, exact integer arithmetic.
// Depends on satpc_pkg for field widths and shape tags.
//
//  channel | ports                                                     | direction
//  input   | in_valid/in_ready, in_shape_sel, in_vertex_x, in_vertex_y, |
//          | in_final_vertex                                           | into block
//  result  | out_valid/out_ready, out_collide, out_shape_error         | out of block
//
// A non-final vertex is stored while idle. A final vertex starts the test:
// a check state, then for each of the nA+nB axes until one separates, E0-E2
// form the axis, each vertex passes the one dot-product unit, a compare state
// tests; a result state loads the result register. A bad shape skips the axes.
// Reset clears the counts and the overflow flag; the vertex store is not cleared.
// in_ready is low while a test runs, and stays low at its end until an earlier
// result has drained; vertices of the next item load while a result waits.
module sat_polygon_collision #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_shape_sel,
  input  logic signed [satpc_pkg::FIELD_W-1:0] in_vertex_x,
  input  logic signed [satpc_pkg::FIELD_W-1:0] in_vertex_y,
  input  logic                                 in_final_vertex,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_collide,
  output logic                                 out_shape_error
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned RAW_W  = (CW > satpc_pkg::FIELD_W) ? CW : satpc_pkg::FIELD_W;
  localparam int unsigned IDX_W  = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned ADDR_W = IDX_W + 1;
  localparam int unsigned MEM_D  = 2 ** ADDR_W;
  localparam int unsigned AX_W   = CW + 1;
  localparam int unsigned PROD_W = 2 * CW + 1;
  localparam int unsigned DOT_W  = 2 * CW + 2;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(3);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_E0    = 4'd2;
  localparam logic [3:0] ST_E1    = 4'd3;
  localparam logic [3:0] ST_E2    = 4'd4;
  localparam logic [3:0] ST_P_RD  = 4'd5;
  localparam logic [3:0] ST_P_MUL = 4'd6;
  localparam logic [3:0] ST_P_ACC = 4'd7;
  localparam logic [3:0] ST_TEST  = 4'd8;
  localparam logic [3:0] ST_RES   = 4'd9;

  // Vertex store, both shapes: entry {y, x}
  logic [2*CW-1:0] mem [MEM_D];
  logic [2*CW-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;

  logic [3:0] state_r, state_nxt;
  logic [CNT_W-1:0] a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt;
  logic ovf_r, ovf_nxt;
  logic poly_r, poly_nxt;                 // shape whose edges give the axes
  logic [IDX_W-1:0] edge_r, edge_nxt;
  logic pshape_r, pshape_nxt;             // shape being projected
  logic [IDX_W-1:0] vidx_r, vidx_nxt;
  logic signed [CW-1:0] x0_r, x0_nxt, y0_r, y0_nxt;
  logic signed [AX_W-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [PROD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [DOT_W-1:0] amin_r, amin_nxt, amax_r, amax_nxt;
  logic signed [DOT_W-1:0] bmin_r, bmin_nxt, bmax_r, bmax_nxt;
  logic hit_r, hit_nxt, err_r, err_nxt;
  logic out_valid_r, out_valid_nxt, out_collide_r, out_collide_nxt;
  logic out_err_r, out_err_nxt;

  logic in_acc;
  logic [RAW_W-1:0] raw_x, raw_y;
  logic signed [CW-1:0] in_x, in_y, rd_x, rd_y;
  logic [CNT_W-1:0] in_cnt, poly_cnt, proj_cnt, edge_inc, vidx_inc;
  logic edge_last, vidx_last, room;
  logic [IDX_W-1:0] edge_next;
  logic signed [DOT_W-1:0] dot;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign raw_x = RAW_W'($unsigned(in_vertex_x));
  assign raw_y = RAW_W'($unsigned(in_vertex_y));
  assign in_x  = raw_x[CW-1:0];
  assign in_y  = raw_y[CW-1:0];
  assign rd_x  = rd_data_r[CW-1:0];
  assign rd_y  = rd_data_r[2*CW-1:CW];

  assign in_cnt   = (in_shape_sel == satpc_pkg::SHAPE_B) ? b_cnt_r : a_cnt_r;
  assign room     = (in_cnt < MAX_CNT);
  assign poly_cnt = (poly_r == satpc_pkg::SHAPE_B) ? b_cnt_r : a_cnt_r;
  assign proj_cnt = (pshape_r == satpc_pkg::SHAPE_B) ? b_cnt_r : a_cnt_r;

  assign edge_inc  = CNT_W'(edge_r) + CNT_W'(1);
  assign edge_last = (edge_inc == poly_cnt);
  assign edge_next = edge_last ? '0 : edge_inc[IDX_W-1:0];
  assign vidx_inc  = CNT_W'(vidx_r) + CNT_W'(1);
  assign vidx_last = (vidx_inc == proj_cnt);

  assign dot = DOT_W'(px_r) + DOT_W'(py_r);

  always_comb begin
    case (state_r)
      ST_E0:   rd_addr = {poly_r, edge_r};
      ST_E1:   rd_addr = {poly_r, edge_next};
      default: rd_addr = {pshape_r, vidx_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      mem[{in_shape_sel, in_cnt[IDX_W-1:0]}] <= {in_y, in_x};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt       = state_r;
    a_cnt_nxt       = a_cnt_r;
    b_cnt_nxt       = b_cnt_r;
    ovf_nxt         = ovf_r;
    poly_nxt        = poly_r;
    edge_nxt        = edge_r;
    pshape_nxt      = pshape_r;
    vidx_nxt        = vidx_r;
    x0_nxt          = x0_r;
    y0_nxt          = y0_r;
    ax_nxt          = ax_r;
    ay_nxt          = ay_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    amin_nxt        = amin_r;
    amax_nxt        = amax_r;
    bmin_nxt        = bmin_r;
    bmax_nxt        = bmax_r;
    hit_nxt         = hit_r;
    err_nxt         = err_r;
    out_valid_nxt   = out_valid_r;
    out_collide_nxt = out_collide_r;
    out_err_nxt     = out_err_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!room) begin
            ovf_nxt = 1'b1;
          end else if (in_shape_sel == satpc_pkg::SHAPE_B) begin
            b_cnt_nxt = b_cnt_r + CNT_W'(1);
          end else begin
            a_cnt_nxt = a_cnt_r + CNT_W'(1);
          end
          if (in_final_vertex) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        poly_nxt = satpc_pkg::SHAPE_A;
        edge_nxt = '0;
        if (ovf_r || a_cnt_r < MIN_CNT || b_cnt_r < MIN_CNT) begin
          hit_nxt   = 1'b0;
          err_nxt   = 1'b1;
          state_nxt = ST_RES;
        end else begin
          err_nxt   = 1'b0;
          state_nxt = ST_E0;
        end
      end
      ST_E0: begin
        state_nxt = ST_E1;
      end
      ST_E1: begin
        // hold the edge start vertex
        x0_nxt    = rd_x;
        y0_nxt    = rd_y;
        state_nxt = ST_E2;
      end
      ST_E2: begin
        ax_nxt     = AX_W'(y0_r) - AX_W'(rd_y);
        ay_nxt     = AX_W'(rd_x) - AX_W'(x0_r);
        pshape_nxt = satpc_pkg::SHAPE_A;
        vidx_nxt   = '0;
        state_nxt  = ST_P_RD;
      end
      ST_P_RD: begin
        state_nxt = ST_P_MUL;
      end
      ST_P_MUL: begin
        px_nxt    = PROD_W'(rd_x) * PROD_W'(ax_r);
        py_nxt    = PROD_W'(rd_y) * PROD_W'(ay_r);
        state_nxt = ST_P_ACC;
      end
      ST_P_ACC: begin
        if (pshape_r == satpc_pkg::SHAPE_B) begin
          if (vidx_r == '0 || dot < bmin_r) bmin_nxt = dot;
          if (vidx_r == '0 || dot > bmax_r) bmax_nxt = dot;
        end else begin
          if (vidx_r == '0 || dot < amin_r) amin_nxt = dot;
          if (vidx_r == '0 || dot > amax_r) amax_nxt = dot;
        end
        if (!vidx_last) begin
          vidx_nxt  = vidx_inc[IDX_W-1:0];
          state_nxt = ST_P_RD;
        end else if (pshape_r == satpc_pkg::SHAPE_A) begin
          pshape_nxt = satpc_pkg::SHAPE_B;
          vidx_nxt   = '0;
          state_nxt  = ST_P_RD;
        end else begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (!(amax_r >= bmin_r && amin_r < bmax_r)) begin
          // separating axis found
          hit_nxt   = 1'b0;
          state_nxt = ST_RES;
        end else if (!edge_last) begin
          edge_nxt  = edge_next;
          state_nxt = ST_E0;
        end else if (poly_r == satpc_pkg::SHAPE_A) begin
          poly_nxt  = satpc_pkg::SHAPE_B;
          edge_nxt  = '0;
          state_nxt = ST_E0;
        end else begin
          hit_nxt   = 1'b1;
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        // wait for the result register to drain, then empty both stores
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_collide_nxt = hit_r;
          out_err_nxt     = err_r;
          a_cnt_nxt       = '0;
          b_cnt_nxt       = '0;
          ovf_nxt         = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_cnt_r     <= a_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    poly_r        <= poly_nxt;
    edge_r        <= edge_nxt;
    pshape_r      <= pshape_nxt;
    vidx_r        <= vidx_nxt;
    x0_r          <= x0_nxt;
    y0_r          <= y0_nxt;
    ax_r          <= ax_nxt;
    ay_r          <= ay_nxt;
    px_r          <= px_nxt;
    py_r          <= py_nxt;
    amin_r        <= amin_nxt;
    amax_r        <= amax_nxt;
    bmin_r        <= bmin_nxt;
    bmax_r        <= bmax_nxt;
    hit_r         <= hit_nxt;
    err_r         <= err_nxt;
    out_collide_r <= out_collide_nxt;
    out_err_r     <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_collide     = out_collide_r;
  assign out_shape_error = out_err_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (a_cnt_r <= MAX_CNT) && (b_cnt_r <= MAX_CNT))
    else $error("vertex count beyond store depth");

  final_starts_test: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_final_vertex) |=> (state_r == ST_CHECK))
    else $error("final vertex did not start the test");

  stores_emptied: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES && state_nxt == ST_IDLE) |=>
      (a_cnt_r == '0 && b_cnt_r == '0 && !ovf_r && out_valid_r))
    else $error("stores not emptied after result");

  error_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_collide_r && out_err_r))
    else $error("collide reported with shape error");
`endif

endmodule

### dv/tb_sat_polygon_collision.sv
// Testbench for sat_polygon_collision: separating axis test of two polygons.
// Depends on satpc_pkg and the block itself. Self-checking, integer-exact,
// with random pacing on both the vertex and the verdict channel.
module tb_sat_polygon_collision;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VTX = 16;
  localparam int COORD_MAX = 2 ** (satpc_pkg::FIELD_W - 1) - 1;
  localparam int COORD_MIN = -(2 ** (satpc_pkg::FIELD_W - 1));
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1500;

  typedef logic signed [satpc_pkg::FIELD_W-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;
  typedef point_t point_q_t[$];
  typedef struct packed {
    logic collide;
    logic shape_error;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_shape_sel;
  coord_t in_vertex_x;
  coord_t in_vertex_y;
  logic in_final_vertex;
  logic out_valid;
  logic out_ready;
  logic out_collide;
  logic out_shape_error;

  sat_polygon_collision #(
    .MAX_VERTICES(MAX_VTX),
    .COORD_WIDTH (satpc_pkg::FIELD_W)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_shape_sel   (in_shape_sel),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_final_vertex(in_final_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_collide    (out_collide),
    .out_shape_error(out_shape_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the vertex stores, indexed by shape tag
  longint held_x[2][MAX_VTX];
  longint held_y[2][MAX_VTX];
  int held_cnt[2];
  bit store_spilled;
  verdict_t verdict_q[$];

  int gap_max;
  int stall_max;
  int items_sent;
  int verdicts_seen;
  int hits_seen;
  int bad_shapes_seen;
  int err_cnt;
  int cycle_cnt;

  function automatic void project_span(int s, longint ax, longint ay,
                                       output longint lo, output longint hi);
    longint d;
    lo = held_x[s][0] * ax + held_y[s][0] * ay;
    hi = lo;
    for (int i = 1; i < held_cnt[s]; i++) begin
      d = held_x[s][i] * ax + held_y[s][i] * ay;
      if (d < lo) lo = d;
      if (d > hi) hi = d;
    end
  endfunction

  // True when some edge normal of shape s splits the two projections
  function automatic bit axis_gap_found(int s);
    int j;
    longint ax, ay, a_lo, a_hi, b_lo, b_hi;
    for (int i = 0; i < held_cnt[s]; i++) begin
      j = (i + 1 == held_cnt[s]) ? 0 : i + 1;
      ax = -(held_y[s][j] - held_y[s][i]);
      ay = held_x[s][j] - held_x[s][i];
      project_span(satpc_pkg::SHAPE_A, ax, ay, a_lo, a_hi);
      project_span(satpc_pkg::SHAPE_B, ax, ay, b_lo, b_hi);
      if (!(a_hi >= b_lo && a_lo < b_hi)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void absorb_vertex(logic sel, point_t p, logic fin);
    int s;
    verdict_t v;
    s = (sel == satpc_pkg::SHAPE_B) ? 1 : 0;
    if (held_cnt[s] < MAX_VTX) begin
      held_x[s][held_cnt[s]] = p.x;
      held_y[s][held_cnt[s]] = p.y;
      held_cnt[s]++;
    end else begin
      store_spilled = 1'b1;
    end
    if (fin) begin
      v.shape_error = store_spilled || held_cnt[0] < 3 || held_cnt[1] < 3;
      v.collide = !v.shape_error && !axis_gap_found(satpc_pkg::SHAPE_A) &&
                  !axis_gap_found(satpc_pkg::SHAPE_B);
      verdict_q.push_back(v);
      held_cnt[0] = 0;
      held_cnt[1] = 0;
      store_spilled = 1'b0;
    end
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic point_t pt(int x, int y);
    point_t p;
    p.x = clamp_coord(x);
    p.y = clamp_coord(y);
    return p;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) + COORD_MIN;
  endfunction

  // Scatter n points around a centre; wide mode draws from the full field range
  function automatic point_q_t scatter(int n, int cx, int cy, int r, bit wide);
    point_q_t q;
    for (int i = 0; i < n; i++) begin
      if (wide)
        q.push_back(pt(rand_coord(), rand_coord()));
      else
        q.push_back(pt(cx + int'($urandom_range(0, 2 * r)) - r,
                       cy + int'($urandom_range(0, 2 * r)) - r));
    end
    return q;
  endfunction

  function automatic point_q_t box(int x0, int y0, int w, int h);
    point_q_t q;
    q.push_back(pt(x0, y0));
    q.push_back(pt(x0 + w, y0));
    q.push_back(pt(x0 + w, y0 + h));
    q.push_back(pt(x0, y0 + h));
    return q;
  endfunction

  // Enter at a falling edge, leave at the falling edge after acceptance
  task automatic send_vertex(logic sel, point_t p, logic fin);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_shape_sel <= sel;
    in_vertex_x <= p.x;
    in_vertex_y <= p.y;
    in_final_vertex <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_vertex(sel, p, fin);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_polygon(logic sel, point_q_t pts, logic ends_test);
    foreach (pts[i]) send_vertex(sel, pts[i], ends_test && i == pts.size() - 1);
  endtask

  // Send both vertex lists, interleaved or not; the last vertex of one shape ends the test
  task automatic send_pair(point_q_t pa, point_q_t pb, bit fin_on_b, bit merge);
    point_t last;
    if (fin_on_b && pb.size() == 0) fin_on_b = 1'b0;
    if (!fin_on_b && pa.size() == 0) fin_on_b = 1'b1;
    last = fin_on_b ? pb.pop_back() : pa.pop_back();
    while (pa.size() + pb.size() != 0) begin
      if (pb.size() == 0 || (pa.size() != 0 && (!merge || $urandom_range(0, 1) == 1)))
        send_vertex(satpc_pkg::SHAPE_A, pa.pop_front(), 1'b0);
      else
        send_vertex(satpc_pkg::SHAPE_B, pb.pop_front(), 1'b0);
    end
    send_vertex(fin_on_b ? satpc_pkg::SHAPE_B : satpc_pkg::SHAPE_A, last, 1'b1);
  endtask

  task automatic test_overlap_final_on_a();
    send_polygon(satpc_pkg::SHAPE_B, '{pt(20, 20), pt(120, 20), pt(20, 120)}, 1'b0);
    send_polygon(satpc_pkg::SHAPE_A, '{pt(0, 0), pt(100, 0), pt(0, 100)}, 1'b1);
  endtask

  // Shared edge, in both orderings: the strict overlap test counts each as apart
  task automatic test_touching_edges();
    send_pair(box(0, 0, 10, 10), box(10, 0, 10, 10), 1'b1, 1'b0);
    send_pair(box(10, 0, 10, 10), box(0, 0, 10, 10), 1'b1, 1'b1);
  endtask

  task automatic test_coordinate_extremes();
    send_pair('{pt(COORD_MIN, COORD_MIN), pt(COORD_MAX, COORD_MIN),
                pt(COORD_MAX, COORD_MAX), pt(COORD_MIN, COORD_MAX)},
              '{pt(COORD_MIN, COORD_MAX), pt(0, COORD_MIN), pt(COORD_MAX, COORD_MAX)},
              1'b1, 1'b0);
    send_pair(box(COORD_MIN, COORD_MIN, 1, 1), box(COORD_MAX - 1, COORD_MAX - 1, 1, 1),
              1'b1, 1'b0);
  endtask

  task automatic test_bad_vertex_counts();
    send_pair(scatter(2, 0, 0, 50, 1'b0), scatter(3, 0, 0, 50, 1'b0), 1'b1, 1'b0);
    send_pair(scatter(3, 0, 0, 50, 1'b0), scatter(2, 0, 0, 50, 1'b0), 1'b1, 1'b0);
    // shape B left empty, test started from shape A
    send_polygon(satpc_pkg::SHAPE_A, scatter(3, 0, 0, 50, 1'b0), 1'b1);
  endtask

  task automatic test_store_overflow();
    send_pair(scatter(MAX_VTX + 1, 0, 0, 400, 1'b0), scatter(3, 0, 0, 400, 1'b0),
              1'b1, 1'b0);
    // flag must have cleared for the next test
    send_pair(scatter(3, 0, 0, 400, 1'b0), scatter(3, 0, 0, 400, 1'b0), 1'b1, 1'b0);
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 24);
    if (r == 0) return MAX_VTX;
    if (r == 1) return $urandom_range(7, MAX_VTX - 1);
    return $urandom_range(3, 6);
  endfunction

  task automatic test_random_polygons(int target);
    int kind, na, nb, r, cx, cy, w, h, n;
    point_q_t pa, pb, tmp;
    while (items_sent < target) begin
      case ($urandom_range(0, 3))
        0: begin gap_max = 0; stall_max = 0; end
        1: begin gap_max = 14; stall_max = 0; end
        2: begin gap_max = 0; stall_max = 14; end
        default: begin gap_max = 14; stall_max = 14; end
      endcase
      kind = $urandom_range(0, 99);
      r = $urandom_range(1, 3000);
      cx = rand_coord();
      cy = rand_coord();
      if (kind < 70) begin
        na = pick_size();
        nb = pick_size();
        pa = scatter(na, cx, cy, r, kind < 12);
        pb = scatter(nb, cx + int'($urandom_range(0, 6 * r)) - 3 * r,
                     cy + int'($urandom_range(0, 6 * r)) - 3 * r, r, kind < 12);
      end else if (kind < 80) begin
        // boxes overlapping slightly, abutting or just apart along x
        w = $urandom_range(1, 2000);
        h = $urandom_range(1, 2000);
        pa = box(cx, cy, w, h);
        pb = box(cx + w + int'($urandom_range(0, 4)) - 2, cy + int'($urandom_range(0, h)),
                 $urandom_range(1, 2000), $urandom_range(1, 2000));
      end else if (kind < 88) begin
        pa = scatter($urandom_range(0, 2), cx, cy, r, 1'b0);
        pb = scatter($urandom_range(1, 5), cx, cy, r, 1'b0);
      end else if (kind < 93) begin
        pa = scatter($urandom_range(MAX_VTX + 1, MAX_VTX + 4), cx, cy, r, 1'b0);
        pb = scatter($urandom_range(3, 5), cx, cy, r, 1'b0);
      end
      // at random, swap so that the short or overfull shape is B
      if (kind >= 80 && kind < 93 && $urandom_range(0, 1) == 1) begin
        tmp = pa;
        pa = pb;
        pb = tmp;
      end
      if (kind < 93) begin
        send_pair(pa, pb, $urandom_range(0, 9) != 0, $urandom_range(0, 1) == 1);
      end else begin
        // loose vertices with occasional test starts
        n = $urandom_range(1, 10);
        repeat (n)
          send_vertex(1'($urandom_range(0, 1)), pt(rand_coord(), rand_coord()),
                      $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("unexpected verdict collide=%0b shape_error=%0b",
                             out_collide, out_shape_error));
      end else begin
        want = verdict_q.pop_front();
        verdicts_seen++;
        hits_seen += want.collide;
        bad_shapes_seen += want.shape_error;
        if (out_collide !== want.collide)
          flag_error($sformatf("collide: expected %0b, got %0b", want.collide, out_collide));
        if (out_shape_error !== want.shape_error)
          flag_error($sformatf("shape_error: expected %0b, got %0b",
                               want.shape_error, out_shape_error));
      end
    end
  end

  // Verdict side: after a verdict is taken, maybe drop ready until the next one has waited a drawn stall
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        hold = $urandom_range(0, stall_max);
        if (hold != 0) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else if (out_valid) begin
        repeat (hold - 1) @(posedge clk);
        @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d verdicts pending", cycle_cnt,
               verdict_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_shape_sel = satpc_pkg::SHAPE_A;
    in_vertex_x = '0;
    in_vertex_y = '0;
    in_final_vertex = 1'b0;
    held_cnt[0] = 0;
    held_cnt[1] = 0;
    store_spilled = 1'b0;
    gap_max = 3;
    stall_max = 3;
    items_sent = 0;
    verdicts_seen = 0;
    hits_seen = 0;
    bad_shapes_seen = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_overlap_final_on_a();
    test_touching_edges();
    test_coordinate_extremes();
    test_bad_vertex_counts();
    test_store_overflow();
    test_random_polygons(items_sent + RANDOM_ITEMS);

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d vertices; checked %0d verdicts (%0d contacts, %0d shape errors)",
             items_sent, verdicts_seen, hits_seen, bad_shapes_seen);
    $display("Mismatches and unexpected verdicts: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
